/* sv/calendar_clock_with_offset_unit_macros.svh */
// Assertion macros shared by the calendar clock RTL.
`ifndef CALENDAR_CLOCK_WITH_OFFSET_UNIT_MACROS_SVH
`define CALENDAR_CLOCK_WITH_OFFSET_UNIT_MACROS_SVH

// Checked on every rising edge of clock, switched off while reset is high.
`define CCO_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising edge of clock, reset included.
`define CCO_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* sv/cco_pkg.sv */
// Types, constants and helper functions of the calendar clock.
`default_nettype none

package cco_pkg;

   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } clk_time_type;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_SET  = 1'b1;

   localparam logic [11:0] YEAR_MAX  = 12'd4095;
   localparam logic [11:0] YEAR_BASE = 12'd2000;
   localparam logic [6:0]  YY_MAX    = 7'd99;
   localparam logic [3:0]  MONTH_JAN = 4'd1;
   localparam logic [3:0]  MONTH_FEB = 4'd2;
   localparam logic [3:0]  MONTH_APR = 4'd4;
   localparam logic [3:0]  MONTH_JUN = 4'd6;
   localparam logic [3:0]  MONTH_SEP = 4'd9;
   localparam logic [3:0]  MONTH_NOV = 4'd11;
   localparam logic [3:0]  MONTH_DEC = 4'd12;
   localparam logic [4:0]  HOUR_MAX  = 5'd23;
   localparam logic [5:0]  MINSEC_MAX = 6'd59;
   localparam logic [4:0]  DAY_FIRST = 5'd1;

   localparam logic signed [10:0] OFFSET_RESET = 11'sd60;

   function automatic logic [4:0] month_length(input logic [3:0] m);
      logic [4:0] len;
      if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV) begin
         len = 5'd30;
      end else if (m == MONTH_FEB) begin
         len = 5'd28;
      end else begin
         len = 5'd31;
      end
      return len;
   endfunction

   function automatic logic [11:0] year_up(input logic [11:0] y);
      return (y < YEAR_MAX) ? y + 12'd1 : y;
   endfunction

   function automatic logic [11:0] year_down(input logic [11:0] y);
      return (y != 12'd0) ? y - 12'd1 : y;
   endfunction

endpackage

`default_nettype wire

/* sv/cco_set.sv */
// Set path: range check, load of the UTC time and application of the minute offset.
`default_nettype none

module cco_set (
   input  logic [6:0]              year_two_digit,
   input  logic [3:0]              month,
   input  logic [4:0]              day,
   input  logic [4:0]              hour,
   input  logic [5:0]              minute,
   input  logic [5:0]              second,
   input  logic signed [10:0]      offset,
   output cco_pkg::clk_time_type   time_out,
   output logic                    rejected
);
   import cco_pkg::*;

   localparam logic signed [12:0] MIN_PER_DAY = 13'sd1440;
   // 65536 / 60 rounded up; exact as a divide by 60 for every value below 1440.
   localparam logic [10:0] HOUR_RECIP = 11'd1093;

   logic [10:0]        hm_base;
   logic signed [12:0] total;
   logic signed [12:0] wrapped_full;
   logic [10:0]        wrapped;
   logic               day_fwd;
   logic               day_back;
   logic [21:0]        hour_prod;
   logic [4:0]         new_hour;
   logic [10:0]        hour_x60;
   logic [10:0]        min_full;
   logic [5:0]         day_shifted;
   logic [4:0]         dim;
   logic [5:0]         day_excess;
   logic [11:0]        year_full;
   logic [3:0]         prev_month;

   assign rejected = (year_two_digit > YY_MAX) || (month == 4'd0) || (month > MONTH_DEC) ||
                     (day == 5'd0) || (hour > HOUR_MAX) || (minute > MINSEC_MAX) ||
                     (second > MINSEC_MAX);

   // Minutes since midnight, then the signed offset.
   assign hm_base = {hour, 6'b0} - {4'b0, hour, 2'b0} + {5'b0, minute};
   assign total   = $signed({2'b00, hm_base}) + 13'(offset);

   always_comb begin
      day_fwd      = 1'b0;
      day_back     = 1'b0;
      wrapped_full = total;
      if (total < 13'sd0) begin
         wrapped_full = total + MIN_PER_DAY;
         day_back     = 1'b1;
      end else if (total >= MIN_PER_DAY) begin
         wrapped_full = total - MIN_PER_DAY;
         day_fwd      = 1'b1;
      end
   end

   assign wrapped   = wrapped_full[10:0];
   assign hour_prod = 22'(wrapped) * 22'(HOUR_RECIP);
   assign new_hour  = hour_prod[20:16];
   assign hour_x60  = {new_hour, 6'b0} - {4'b0, new_hour, 2'b0};
   assign min_full  = wrapped - hour_x60;

   assign dim         = month_length(month);
   assign year_full   = YEAR_BASE + 12'(year_two_digit);
   assign day_shifted = day_fwd  ? {1'b0, day} + 6'd1 :
                        day_back ? {1'b0, day} - 6'd1 : {1'b0, day};
   assign day_excess  = day_shifted - {1'b0, dim};
   assign prev_month  = (month == MONTH_JAN) ? MONTH_DEC : month - 4'd1;

   always_comb begin
      time_out.year   = year_full;
      time_out.month  = month;
      time_out.day    = day;
      time_out.hour   = new_hour;
      time_out.minute = min_full[5:0];
      time_out.second = second;
      // A day that did not move is kept as given, even past its month end.
      if (day_fwd || day_back) begin
         time_out.day = day_shifted[4:0];
         if (day_shifted > {1'b0, dim}) begin
            time_out.day = day_excess[4:0];
            if (month == MONTH_DEC) begin
               time_out.month = MONTH_JAN;
               time_out.year  = year_up(year_full);
            end else begin
               time_out.month = month + 4'd1;
            end
         end else if (day_shifted == 6'd0) begin
            time_out.month = prev_month;
            time_out.day   = month_length(prev_month);
            if (month == MONTH_JAN) begin
               time_out.year = year_down(year_full);
            end
         end
      end
   end

endmodule

`default_nettype wire

/* sv/cco_tick.sv */
// Tick path: advances a valid clock by one second through the calendar cascade.
`default_nettype none

module cco_tick (
   input  cco_pkg::clk_time_type cur,
   input  logic                  time_valid,
   output cco_pkg::clk_time_type time_out
);
   import cco_pkg::*;

   logic [6:0] sec_inc;
   logic [6:0] min_inc;
   logic [5:0] hour_inc;
   logic [5:0] day_inc;
   logic [4:0] month_inc;

   assign sec_inc   = {1'b0, cur.second} + 7'd1;
   assign min_inc   = {1'b0, cur.minute} + 7'd1;
   assign hour_inc  = {1'b0, cur.hour} + 6'd1;
   assign day_inc   = {1'b0, cur.day} + 6'd1;
   assign month_inc = {1'b0, cur.month} + 5'd1;

   always_comb begin
      time_out = cur;
      if (time_valid) begin
         time_out.second = sec_inc[5:0];
         if (sec_inc > {1'b0, MINSEC_MAX}) begin
            time_out.second = 6'd0;
            time_out.minute = min_inc[5:0];
            if (min_inc > {1'b0, MINSEC_MAX}) begin
               time_out.minute = 6'd0;
               time_out.hour   = hour_inc[4:0];
               if (hour_inc > {1'b0, HOUR_MAX}) begin
                  time_out.hour = 5'd0;
                  time_out.day  = day_inc[4:0];
                  if (day_inc > {1'b0, month_length(cur.month)}) begin
                     time_out.day   = DAY_FIRST;
                     time_out.month = month_inc[3:0];
                     if (month_inc > {1'b0, MONTH_DEC}) begin
                        time_out.month = MONTH_JAN;
                        time_out.year  = year_up(cur.year);
                     end
                  end
               end
            end
         end
      end
   end

endmodule

`default_nettype wire

/* sv/calendar_clock_with_offset_unit.sv */
// Top level of the calendar clock with local time offset.
`default_nettype none

`include "calendar_clock_with_offset_unit_macros.svh"

// Calendar clock with a local offset. The block keeps year, month, day, hour,
// minute and second plus a valid flag. A set transaction loads a UTC time
// (year 2000 plus two digits), marks the clock valid and adds the signed minute
// offset held in the csr register; crossing midnight moves the day, which is
// then normalized through 31/30/28-day months with no leap years. A tick
// transaction advances the clock by one second once it is valid. A set with any
// field out of range leaves the clock untouched and returns set_rejected high.
// Every request transaction returns exactly one response transaction carrying
// the clock as it stands after that request. Throughput is one transaction per
// cycle while rsp_ready stays high. An accepted request waits in the input
// register until the response register is empty or being drained, and is then
// written into it, raising rsp_valid; all calendar arithmetic is done in a
// single pass between the two registers. While a response waits on a low
// rsp_ready, one more request can be taken into the input register, after
// which req_ready stays low until the response is taken. The offset register
// resets to 60 minutes and may be written only while no transaction is in
// flight.
module calendar_clock_with_offset_unit (
   input  logic               clock,
   input  logic               reset,
   // Configuration port.
   input  logic               csr_wr_en,
   input  logic [10:0]        csr_wr_data,
   // Request channel.
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_operation,
   input  logic [6:0]         req_set_year_two_digit,
   input  logic [3:0]         req_set_month,
   input  logic [4:0]         req_set_day,
   input  logic [4:0]         req_set_hour,
   input  logic [5:0]         req_set_minute,
   input  logic [5:0]         req_set_second,
   // Response channel.
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [11:0]        rsp_year_out,
   output logic [3:0]         rsp_month_out,
   output logic [4:0]         rsp_day_out,
   output logic [4:0]         rsp_hour_out,
   output logic [5:0]         rsp_minute_out,
   output logic [5:0]         rsp_second_out,
   output logic               rsp_valid_out,
   output logic               rsp_set_rejected
);
   import cco_pkg::*;

   // Offset register.
   logic signed [10:0] offset_ff;

   // Input register stage.
   logic       in_vld_ff;
   logic       in_op_ff;
   logic [6:0] in_year_ff;
   logic [3:0] in_month_ff;
   logic [4:0] in_day_ff;
   logic [4:0] in_hour_ff;
   logic [5:0] in_minute_ff;
   logic [5:0] in_second_ff;

   // Clock state.
   clk_time_type time_ff;
   clk_time_type time_in;
   logic         valid_ff;
   logic         valid_in;

   // Response register stage.
   logic         rsp_vld_ff;
   clk_time_type rsp_time_ff;
   logic         rsp_tvalid_ff;
   logic         rsp_rej_ff;
   logic         rej_in;

   clk_time_type set_time;
   logic         set_rej;
   clk_time_type tick_time;
   logic         advance;
   logic         accept;

   // The input stage moves on whenever the response register is empty or being
   // drained, so a response that is taken in the same cycle never blocks the
   // next request.
   assign advance   = in_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || advance;
   assign accept    = req_valid && req_ready;

   cco_set u_set (
      .year_two_digit (in_year_ff),
      .month          (in_month_ff),
      .day            (in_day_ff),
      .hour           (in_hour_ff),
      .minute         (in_minute_ff),
      .second         (in_second_ff),
      .offset         (offset_ff),
      .time_out       (set_time),
      .rejected       (set_rej)
   );

   cco_tick u_tick (
      .cur        (time_ff),
      .time_valid (valid_ff),
      .time_out   (tick_time)
   );

   // Select the new clock state for the transaction in the input stage.
   always_comb begin
      time_in  = time_ff;
      valid_in = valid_ff;
      rej_in   = 1'b0;
      if (in_op_ff == OP_SET) begin
         rej_in = set_rej;
         if (!set_rej) begin
            time_in  = set_time;
            valid_in = 1'b1;
         end
      end else begin
         time_in = tick_time;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= OFFSET_RESET;
      end else if (csr_wr_en) begin
         offset_ff <= $signed(csr_wr_data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (accept) begin
         in_vld_ff <= 1'b1;
      end else if (advance) begin
         in_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_op_ff     <= req_operation;
         in_year_ff   <= req_set_year_two_digit;
         in_month_ff  <= req_set_month;
         in_day_ff    <= req_set_day;
         in_hour_ff   <= req_set_hour;
         in_minute_ff <= req_set_minute;
         in_second_ff <= req_set_second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff  <= '0;
         valid_ff <= 1'b0;
      end else if (advance) begin
         time_ff  <= time_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_time_ff   <= time_in;
         rsp_tvalid_ff <= valid_in;
         rsp_rej_ff    <= rej_in;
      end
   end

   assign rsp_valid        = rsp_vld_ff;
   assign rsp_year_out     = rsp_time_ff.year;
   assign rsp_month_out    = rsp_time_ff.month;
   assign rsp_day_out      = rsp_time_ff.day;
   assign rsp_hour_out     = rsp_time_ff.hour;
   assign rsp_minute_out   = rsp_time_ff.minute;
   assign rsp_second_out   = rsp_time_ff.second;
   assign rsp_valid_out    = rsp_tvalid_ff;
   assign rsp_set_rejected = rsp_rej_ff;

   // Once set, the clock never loses its valid flag short of reset.
   `CCO_ASSERT(a_valid_sticky, valid_ff |=> valid_ff, "clock lost its valid flag")

   // A valid clock always holds a legal time of day and month.
   `CCO_ASSERT_ALWAYS(a_time_legal, valid_ff |-> (time_ff.hour <= HOUR_MAX &&
      time_ff.minute <= MINSEC_MAX && time_ff.second <= MINSEC_MAX &&
      time_ff.month >= MONTH_JAN && time_ff.month <= MONTH_DEC),
      "valid clock holds an illegal time")

   // A rejected set leaves the clock as it was.
   `CCO_ASSERT(a_reject_keeps, (advance && rej_in) |=> $stable(time_ff) && $stable(valid_ff),
      "rejected set changed the clock")

   // A tick before the first set does not move the clock.
   `CCO_ASSERT(a_idle_tick, (advance && in_op_ff == OP_TICK && !valid_ff) |=> $stable(time_ff),
      "tick moved an unset clock")

   // Every transaction that leaves the input stage shows up as a response.
   `CCO_ASSERT(a_advance_rsp, advance |=> rsp_vld_ff, "transaction lost between stages")

endmodule

`default_nettype wire

/* tb/calendar_clock_with_offset_unit_tb.sv */
// Self-checking testbench for the calendar clock with local time offset.
module calendar_clock_with_offset_unit_tb;
   import cco_pkg::*;

   // Bench timing and pacing.
   localparam int HALF_PERIOD   = 4;
   localparam int RESET_CYCLES  = 10;
   localparam int IDLE_PERCENT  = 9;
   localparam int SETTLE_CYCLES = 8;
   localparam int STALL_LIMIT   = 2000;
   localparam int REPORT_LIMIT  = 10;
   localparam int RANDOM_PER_PHASE = 150;
   localparam int MINUTES_PER_DAY  = 1440;

   // One request transaction as it appears on the req_ ports.
   typedef struct {
      logic       op;
      logic [6:0] yy;
      logic [3:0] mo;
      logic [4:0] dd;
      logic [4:0] hh;
      logic [5:0] mi;
      logic [5:0] ss;
   } clock_cmd_type;

   // One clock reading as it appears on the rsp_ ports.
   typedef struct {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic        valid;
      logic        rejected;
   } clock_reading_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [10:0] csr_wr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_operation = OP_TICK;
   logic [6:0]  req_set_year_two_digit = '0;
   logic [3:0]  req_set_month = '0;
   logic [4:0]  req_set_day = '0;
   logic [4:0]  req_set_hour = '0;
   logic [5:0]  req_set_minute = '0;
   logic [5:0]  req_set_second = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [11:0] rsp_year_out;
   logic [3:0]  rsp_month_out;
   logic [4:0]  rsp_day_out;
   logic [4:0]  rsp_hour_out;
   logic [5:0]  rsp_minute_out;
   logic [5:0]  rsp_second_out;
   logic        rsp_valid_out;
   logic        rsp_set_rejected;

   // Commands waiting to be driven, and readings the block still owes us.
   clock_cmd_type     cmd_backlog[$];
   clock_reading_type reading_expected[$];

   int  cmds_queued = 0;
   int  cmds_accepted = 0;
   int  mismatch_count = 0;
   int  stall_cycles = 0;
   bit  req_fired = 1'b0;
   bit  steady_flow = 1'b0;

   // The predictor's own copy of the calendar and of the offset register.
   int  cal_year = 0;
   int  cal_month = 0;
   int  cal_day = 0;
   int  cal_hour = 0;
   int  cal_minute = 0;
   int  cal_second = 0;
   bit  cal_valid = 1'b0;
   int  zone_offset = int'(OFFSET_RESET);

   calendar_clock_with_offset_unit u_dut (
      .clock                  (clock),
      .reset                  (reset),
      .csr_wr_en              (csr_wr_en),
      .csr_wr_data            (csr_wr_data),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_operation          (req_operation),
      .req_set_year_two_digit (req_set_year_two_digit),
      .req_set_month          (req_set_month),
      .req_set_day            (req_set_day),
      .req_set_hour           (req_set_hour),
      .req_set_minute         (req_set_minute),
      .req_set_second         (req_set_second),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_year_out           (rsp_year_out),
      .rsp_month_out          (rsp_month_out),
      .rsp_day_out            (rsp_day_out),
      .rsp_hour_out           (rsp_hour_out),
      .rsp_minute_out         (rsp_minute_out),
      .rsp_second_out         (rsp_second_out),
      .rsp_valid_out          (rsp_valid_out),
      .rsp_set_rejected       (rsp_set_rejected)
   );

   initial begin
      forever #HALF_PERIOD clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Calendar predictor.
   // ------------------------------------------------------------------

   // Month lengths with no leap years. An unset month (zero) counts as long.
   function automatic int days_in_month(int m);
      if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV) begin
         return 30;
      end
      if (m == MONTH_FEB) begin
         return 28;
      end
      return 31;
   endfunction

   // The year stops at the top of its 12-bit range instead of wrapping.
   function automatic void advance_year();
      if (cal_year < int'(YEAR_MAX)) begin
         cal_year++;
      end
   endfunction

   // Adds the local offset to a freshly loaded UTC time. Only a crossing of
   // midnight touches the date; the day then walks through the month lengths
   // in either direction, carrying into the month and the year.
   function automatic void shift_to_local(int delta);
      int total;
      int carry = 0;
      if (!cal_valid || delta == 0) begin
         return;
      end
      total = cal_hour * 60 + cal_minute + delta;
      if (total < 0) begin
         total += MINUTES_PER_DAY;
         carry = -1;
      end else if (total >= MINUTES_PER_DAY) begin
         total -= MINUTES_PER_DAY;
         carry = 1;
      end
      cal_hour = total / 60;
      cal_minute = total % 60;
      if (carry == 0) begin
         return;
      end
      cal_day += carry;
      for (int pass = 0; pass < 4; pass++) begin
         if (cal_day > days_in_month(cal_month)) begin
            cal_day -= days_in_month(cal_month);
            cal_month++;
            if (cal_month > 12) begin
               cal_month = 1;
               advance_year();
            end
         end else if (cal_day <= 0) begin
            cal_month--;
            if (cal_month < 1) begin
               cal_month = 12;
               if (cal_year > 0) begin
                  cal_year--;
               end
            end
            cal_day += days_in_month(cal_month);
         end else begin
            break;
         end
      end
   endfunction

   // One elapsed second. Note that a day already past its month's length
   // (such as a 31st of February that was set directly) rolls over to the
   // first of the next month at the next midnight.
   function automatic void count_one_second();
      if (!cal_valid) begin
         return;
      end
      cal_second++;
      if (cal_second >= 60) begin
         cal_second = 0;
         cal_minute++;
      end
      if (cal_minute >= 60) begin
         cal_minute = 0;
         cal_hour++;
      end
      if (cal_hour >= 24) begin
         cal_hour = 0;
         cal_day++;
         if (cal_day > days_in_month(cal_month)) begin
            cal_day = 1;
            cal_month++;
            if (cal_month > 12) begin
               cal_month = 1;
               advance_year();
            end
         end
      end
   endfunction

   // Applies one command to the predicted calendar and returns the reading
   // that the block must report for it.
   function automatic clock_reading_type next_reading(clock_cmd_type c);
      clock_reading_type r;
      r.rejected = 1'b0;
      if (c.op == OP_SET) begin
         if (c.yy > YY_MAX || c.mo < MONTH_JAN || c.mo > MONTH_DEC || c.dd < DAY_FIRST ||
             c.hh > HOUR_MAX || c.mi > MINSEC_MAX || c.ss > MINSEC_MAX) begin
            r.rejected = 1'b1;
         end else begin
            cal_year   = int'(YEAR_BASE) + int'(c.yy);
            cal_month  = int'(c.mo);
            cal_day    = int'(c.dd);
            cal_hour   = int'(c.hh);
            cal_minute = int'(c.mi);
            cal_second = int'(c.ss);
            cal_valid  = 1'b1;
            shift_to_local(zone_offset);
         end
      end else begin
         count_one_second();
      end
      r.year   = 12'(cal_year);
      r.month  = 4'(cal_month);
      r.day    = 5'(cal_day);
      r.hour   = 5'(cal_hour);
      r.minute = 6'(cal_minute);
      r.second = 6'(cal_second);
      r.valid  = cal_valid;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Driver. Request and ready inputs change on the falling edge only, so
   // the block always samples settled values at the rising edge. A request
   // transaction is held until the monitor has seen it accepted.
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      bit            send_now;
      clock_cmd_type c;
      if (!reset) begin
         if (!req_valid || req_fired) begin
            send_now = cmd_backlog.size() != 0 &&
                       (steady_flow || $urandom_range(99) >= IDLE_PERCENT);
            if (send_now) begin
               c = cmd_backlog.pop_front();
               req_operation          <= c.op;
               req_set_year_two_digit <= c.yy;
               req_set_month          <= c.mo;
               req_set_day            <= c.dd;
               req_set_hour           <= c.hh;
               req_set_minute         <= c.mi;
               req_set_second         <= c.ss;
            end
            req_valid <= send_now;
         end
         rsp_ready <= steady_flow || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // Compares one field of a reading; only the first few mismatches are shown.
   task automatic check_field(string field, logic [11:0] want, logic [11:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT) begin
            $display("%s mismatch: expected %0d, got %0d", field, want, got);
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Monitor. Everything is sampled at the rising edge. An accepted request
   // is predicted before the response side is looked at, so an expectation
   // always exists before the reading that answers it can arrive.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      clock_cmd_type     cmd;
      clock_reading_type got;
      clock_reading_type want;
      bit                rsp_fired;
      if (reset) begin
         req_fired = 1'b0;
         stall_cycles = 0;
      end else begin
         req_fired = req_valid && req_ready;
         rsp_fired = rsp_valid && rsp_ready;
         if (req_fired) begin
            cmd.op = req_operation;
            cmd.yy = req_set_year_two_digit;
            cmd.mo = req_set_month;
            cmd.dd = req_set_day;
            cmd.hh = req_set_hour;
            cmd.mi = req_set_minute;
            cmd.ss = req_set_second;
            reading_expected.push_back(next_reading(cmd));
            cmds_accepted++;
         end
         if (rsp_fired) begin
            got.year     = rsp_year_out;
            got.month    = rsp_month_out;
            got.day      = rsp_day_out;
            got.hour     = rsp_hour_out;
            got.minute   = rsp_minute_out;
            got.second   = rsp_second_out;
            got.valid    = rsp_valid_out;
            got.rejected = rsp_set_rejected;
            if (reading_expected.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("response transaction with no request outstanding");
               end
            end else begin
               want = reading_expected.pop_front();
               check_field("year", want.year, got.year);
               check_field("month", 12'(want.month), 12'(got.month));
               check_field("day", 12'(want.day), 12'(got.day));
               check_field("hour", 12'(want.hour), 12'(got.hour));
               check_field("minute", 12'(want.minute), 12'(got.minute));
               check_field("second", 12'(want.second), 12'(got.second));
               check_field("valid_out", 12'(want.valid), 12'(got.valid));
               check_field("set_rejected", 12'(want.rejected), 12'(got.rejected));
            end
         end
         stall_cycles = (req_fired || rsp_fired) ? 0 : stall_cycles + 1;
      end
   end

   // Watchdog: a run in which no transaction moves for too long is hung.
   initial begin
      do @(negedge clock); while (stall_cycles < STALL_LIMIT);
      $display("calendar_clock_with_offset_unit verification failed");
      $finish;
   end

   // ------------------------------------------------------------------
   // Stimulus helpers. They are called right after a rising edge, so the
   // backlog never changes at an edge where the driver reads it.
   // ------------------------------------------------------------------
   task automatic push_set(int yy, int mo, int dd, int hh, int mi, int ss);
      clock_cmd_type c;
      c.op = OP_SET;
      c.yy = 7'(yy);
      c.mo = 4'(mo);
      c.dd = 5'(dd);
      c.hh = 5'(hh);
      c.mi = 6'(mi);
      c.ss = 6'(ss);
      cmd_backlog.push_back(c);
      cmds_queued++;
   endtask

   // A tick carries random junk in the set fields, which the block must ignore.
   task automatic push_tick(int count);
      clock_cmd_type c;
      for (int n = 0; n < count; n++) begin
         c.op = OP_TICK;
         c.yy = 7'($urandom);
         c.mo = 4'($urandom);
         c.dd = 5'($urandom);
         c.hh = 5'($urandom);
         c.mi = 6'($urandom);
         c.ss = 6'($urandom);
         cmd_backlog.push_back(c);
         cmds_queued++;
      end
   endtask

   // Picks the low end, the high end or anything in between.
   function automatic int near_limit(int lo, int hi);
      int pick = $urandom_range(3);
      if (pick == 0) begin
         return lo;
      end
      if (pick == 1) begin
         return hi;
      end
      return $urandom_range(hi, lo);
   endfunction

   // Mostly a legal set close to some calendar boundary followed by a short
   // burst of ticks, so that roll-overs really happen. The rest is raw noise
   // in every set field (which also covers every bit of every field) and
   // lone ticks.
   task automatic push_random_traffic(int count);
      int made = 0;
      int pick;
      int burst;
      while (made < count) begin
         pick = $urandom_range(99);
         if (pick < 65) begin
            burst = $urandom_range(8, 1);
            push_set(near_limit(0, 99), near_limit(1, 12),
                     $urandom_range(1) ? near_limit(28, 31) : $urandom_range(31, 1),
                     near_limit(0, 23), near_limit(0, 59), near_limit(55, 59));
            push_tick(burst);
            made += 1 + burst;
         end else if (pick < 80) begin
            push_set($urandom_range(127), $urandom_range(15), $urandom_range(31),
                     $urandom_range(31), $urandom_range(63), $urandom_range(63));
            made++;
         end else begin
            push_tick(1);
            made++;
         end
      end
   endtask

   // Waits until every queued request has been accepted and answered, then
   // lets the pipeline settle so that it is truly empty.
   task automatic wait_until_idle();
      do @(negedge clock);
      while (cmds_accepted != cmds_queued || reading_expected.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Writes the offset register while nothing is in flight.
   task automatic program_offset(int minutes);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_wr_data = 11'(minutes);
      @(negedge clock);
      csr_wr_en = 1'b0;
      zone_offset = minutes;
   endtask

   // ------------------------------------------------------------------
   // Test sequence. Each phase after the first writes a new offset into an idle
   // block, queues its commands and then pauses the sender until every reading is back.
   // ------------------------------------------------------------------
   initial begin
      repeat (RESET_CYCLES) @(negedge clock);
      reset = 1'b0;

      // Directed checks with the offset still at its reset value of +60.
      @(posedge clock);
      push_tick(1);                    // a tick before any set changes nothing
      push_set(99, 12, 31, 23, 30, 0); // midnight crossing rolls into the next century
      push_set(0, 1, 1, 0, 0, 0);      // same day, only the hour moves
      push_set(100, 1, 1, 0, 0, 0);    // every kind of out-of-range set field
      push_set(127, 15, 31, 31, 63, 63);
      push_set(5, 0, 1, 0, 0, 0);
      push_set(5, 13, 1, 0, 0, 0);
      push_set(5, 3, 0, 0, 0, 0);
      push_set(5, 3, 3, 24, 0, 0);
      push_set(5, 3, 3, 3, 60, 0);
      push_set(5, 3, 3, 3, 3, 60);
      push_set(21, 4, 31, 23, 30, 10); // April 31st pushed past midnight lands in May
      push_set(21, 2, 31, 10, 0, 0);   // February 31st kept while the day is unchanged
      push_set(99, 12, 31, 22, 59, 59);
      push_tick(1);                    // full cascade from second up to year
      wait_until_idle();

      // Most negative offset: midnight crossed backward into the old year.
      program_offset(-720);
      @(posedge clock);
      push_set(0, 1, 1, 5, 0, 0);
      push_set(21, 3, 1, 11, 59, 0);
      push_random_traffic(RANDOM_PER_PHASE);
      wait_until_idle();

      // Most positive offset, run with both sides always ready.
      program_offset(840);
      @(posedge clock);
      steady_flow = 1'b1;
      push_set(0, 12, 31, 12, 0, 0);
      push_random_traffic(RANDOM_PER_PHASE);
      wait_until_idle();
      steady_flow = 1'b0;

      // Zero offset: out-of-month days stay as given until a tick rolls them.
      program_offset(0);
      @(posedge clock);
      push_set(21, 2, 31, 23, 59, 59);
      push_tick(1);
      push_set(21, 11, 31, 23, 59, 58);
      push_tick(2);
      push_random_traffic(RANDOM_PER_PHASE);
      wait_until_idle();

      program_offset(int'($urandom_range(1560)) - 720);
      @(posedge clock);
      push_random_traffic(RANDOM_PER_PHASE);
      wait_until_idle();

      program_offset(-1);
      @(posedge clock);
      push_random_traffic(RANDOM_PER_PHASE);
      wait_until_idle();

      program_offset(int'($urandom_range(1560)) - 720);
      @(posedge clock);
      push_random_traffic(RANDOM_PER_PHASE);
      wait_until_idle();

      if (mismatch_count == 0 && reading_expected.size() == 0) begin
         $display("calendar_clock_with_offset_unit verification clean");
      end else begin
         $display("calendar_clock_with_offset_unit verification failed");
      end
      $finish;
   end

endmodule
